/* rtl/rpn_stack_calculator_defines.svh */
// Assertion macros used by the checker file of the stack calculator.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define RPN_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define RPN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/rpn_pkg.sv */
// Shared constants and codes of the reverse-Polish stack calculator.
`timescale 1ns / 1ps

package rpn_pkg;

    localparam int OP_W                = 4;
    localparam int DATA_W              = 32;
    localparam int STATUS_W            = 3;
    localparam int DEFAULT_STACK_DEPTH = 64;

    // Operation codes carried on the input channel.
    localparam logic [OP_W-1:0] OP_PUSH     = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 4'd1;
    localparam logic [OP_W-1:0] OP_SUB      = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL      = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV      = 4'd4;
    localparam logic [OP_W-1:0] OP_NEG      = 4'd5;
    localparam logic [OP_W-1:0] OP_DUP      = 4'd6;
    localparam logic [OP_W-1:0] OP_SWAP     = 4'd7;
    localparam logic [OP_W-1:0] OP_SHOW_TOP = 4'd8;
    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd9;
    localparam logic [OP_W-1:0] OP_SHOW_ALL = 4'd10;

    // Status codes carried on the result channel.
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SHOWN   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FEW     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DIVZERO = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd5;

endpackage

/* rtl/rpn_stack_calculator.sv */
// Top level of the reverse-Polish integer stack calculator.
`timescale 1ns / 1ps
// Usage
// The input channel (s_) carries one operation per item: s_tuser holds the
// operation code and s_tdata the value that a push places on the stack. The
// result channel (m_) returns one item per operation, or one item per stack
// entry for show all, listed from top to bottom with m_tlast on the final one.
// m_tuser holds the status and m_tdata the entry shown, zero otherwise.
// The stack lives in a single-port-read, single-port-write memory with a
// registered read; the entry count sits in a register. Items are taken
// one at a time. Push, clear and errors found from the count go from idle
// straight to the emit state; negate, dup, show top and divide by zero read
// the top first; add, subtract, multiply and swap read the top and the entry
// below, then write back; divide reads both and waits for the divider, which
// retires one quotient bit per cycle. Show all reads and emits entries in turn.
// The input is taken again once the last result has entered the output
// register, so a waiting result does not hold back the next operation.
// Reset empties the stack at once (the count goes to zero; the memory is not
// cleared). While the receiver stalls, the pending result holds in the output
// register and the sequencer waits before it loads the next one.

module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rpn_pkg::DATA_W-1:0]   s_tdata,   // push_value
    input  logic [rpn_pkg::OP_W-1:0]     s_tuser,   // operation
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rpn_pkg::DATA_W-1:0]   m_tdata,   // shown_value
    output logic [rpn_pkg::STATUS_W-1:0] m_tuser,   // status
    output logic                         m_tlast    // last_result
);

    localparam int DW     = rpn_pkg::DATA_W;
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    // Sequencer states.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RD_TOP    = 4'd1;
    localparam logic [3:0] S_RD_BELOW  = 4'd2;
    localparam logic [3:0] S_EXEC      = 4'd3;
    localparam logic [3:0] S_SWAP2     = 4'd4;
    localparam logic [3:0] S_DIV_WAIT  = 4'd5;
    localparam logic [3:0] S_LIST_RD   = 4'd6;
    localparam logic [3:0] S_LIST_WAIT = 4'd7;
    localparam logic [3:0] S_EMIT      = 4'd8;

    // The stack store: entry 0 is the bottom, entry count-1 the top.
    logic [DW-1:0] stack_mem [STACK_DEPTH];
    logic [DW-1:0] rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [3:0]                     state_reg,  state_next;
    logic [CNT_W-1:0]               cnt_reg,    cnt_next;
    logic [rpn_pkg::OP_W-1:0]       op_reg,     op_next;
    logic [DW-1:0]                  top_reg,    top_next;
    logic [DW-1:0]                  below_reg,  below_next;
    logic [ADDR_W-1:0]              list_reg,   list_next;
    logic [rpn_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [DW-1:0]                  res_value_reg,  res_value_next;
    logic                           res_last_reg,   res_last_next;

    logic                           m_valid_reg,  m_valid_next;
    logic [DW-1:0]                  m_data_reg,   m_data_next;
    logic [rpn_pkg::STATUS_W-1:0]   m_user_reg,   m_user_next;
    logic                           m_last_reg,   m_last_next;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [ADDR_W-1:0] addr_push;
    logic [ADDR_W-1:0] addr_top;
    logic [ADDR_W-1:0] addr_below;
    logic              is_full;
    logic [DW-1:0]     alu_res;

    logic              div_start;
    logic              div_done;
    logic [DW-1:0]     div_quo;

    assign cnt_m1     = cnt_reg - CNT_W'(1);
    assign cnt_m2     = cnt_reg - CNT_W'(2);
    assign addr_push  = cnt_reg[ADDR_W-1:0];
    assign addr_top   = cnt_m1[ADDR_W-1:0];
    assign addr_below = cnt_m2[ADDR_W-1:0];
    assign is_full    = (cnt_reg == FULL_CNT);

    // Add, subtract and multiply work on the two registered operands.
    always_comb begin
        case (op_reg)
            rpn_pkg::OP_ADD: alu_res = below_reg + top_reg;
            rpn_pkg::OP_SUB: alu_res = below_reg - top_reg;
            default:         alu_res = below_reg * top_reg;
        endcase
    end

    rpn_div u_rpn_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (below_next),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_tready = (state_reg == S_IDLE);

    // Main sequencer. Each item reads the entries it needs one at a time, then
    // writes back; no read and write ever target the same entry in one cycle,
    // so the ordering of the states is the only interlock needed.
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        top_next        = top_reg;
        below_next      = below_reg;
        list_next       = list_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_last_next   = res_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_top;
        mem_wdata       = rd_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = addr_top;
        div_start       = 1'b0;

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_tuser;
                    res_status_next = rpn_pkg::STAT_OK;
                    res_value_next  = '0;
                    res_last_next   = 1'b1;
                    state_next      = S_EMIT;
                    unique case (s_tuser) inside
                        rpn_pkg::OP_PUSH: begin
                            if (is_full) begin
                                res_status_next = rpn_pkg::STAT_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = addr_push;
                                mem_wdata = s_tdata;
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
                        rpn_pkg::OP_DIV, rpn_pkg::OP_SWAP: begin
                            if (cnt_reg < CNT_W'(2)) begin
                                res_status_next = rpn_pkg::STAT_FEW;
                            end else begin
                                mem_re     = 1'b1;
                                state_next = S_RD_TOP;
                            end
                        end
                        rpn_pkg::OP_NEG, rpn_pkg::OP_SHOW_TOP: begin
                            if (cnt_reg == '0) begin
                                res_status_next = rpn_pkg::STAT_FEW;
                            end else begin
                                mem_re     = 1'b1;
                                state_next = S_RD_TOP;
                            end
                        end
                        rpn_pkg::OP_DUP: begin
                            if (cnt_reg == '0) begin
                                res_status_next = rpn_pkg::STAT_FEW;
                            end else if (is_full) begin
                                res_status_next = rpn_pkg::STAT_FULL;
                            end else begin
                                mem_re     = 1'b1;
                                state_next = S_RD_TOP;
                            end
                        end
                        rpn_pkg::OP_CLEAR: begin
                            cnt_next = '0;
                        end
                        rpn_pkg::OP_SHOW_ALL: begin
                            if (cnt_reg == '0) begin
                                res_status_next = rpn_pkg::STAT_EMPTY;
                            end else begin
                                list_next  = addr_top;
                                state_next = S_LIST_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_RD_TOP: begin
                top_next = rd_data_reg;
                unique case (op_reg) inside
                    rpn_pkg::OP_NEG: begin
                        mem_we     = 1'b1;
                        mem_waddr  = addr_top;
                        mem_wdata  = DW'(0) - rd_data_reg;
                        state_next = S_EMIT;
                    end
                    rpn_pkg::OP_DUP: begin
                        mem_we     = 1'b1;
                        mem_waddr  = addr_push;
                        mem_wdata  = rd_data_reg;
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_EMIT;
                    end
                    rpn_pkg::OP_SHOW_TOP: begin
                        res_status_next = rpn_pkg::STAT_SHOWN;
                        res_value_next  = rd_data_reg;
                        state_next      = S_EMIT;
                    end
                    rpn_pkg::OP_DIV: begin
                        if (rd_data_reg == '0) begin
                            res_status_next = rpn_pkg::STAT_DIVZERO;
                            state_next      = S_EMIT;
                        end else begin
                            mem_re     = 1'b1;
                            mem_raddr  = addr_below;
                            state_next = S_RD_BELOW;
                        end
                    end
                    default: begin
                        mem_re     = 1'b1;
                        mem_raddr  = addr_below;
                        state_next = S_RD_BELOW;
                    end
                endcase
            end

            S_RD_BELOW: begin
                below_next = rd_data_reg;
                unique case (op_reg) inside
                    rpn_pkg::OP_SWAP: begin
                        mem_we     = 1'b1;
                        mem_waddr  = addr_top;
                        mem_wdata  = rd_data_reg;
                        state_next = S_SWAP2;
                    end
                    rpn_pkg::OP_DIV: begin
                        div_start  = 1'b1;
                        state_next = S_DIV_WAIT;
                    end
                    default: begin
                        state_next = S_EXEC;
                    end
                endcase
            end

            S_EXEC: begin
                mem_we     = 1'b1;
                mem_waddr  = addr_below;
                mem_wdata  = alu_res;
                cnt_next   = cnt_m1;
                state_next = S_EMIT;
            end

            S_SWAP2: begin
                mem_we     = 1'b1;
                mem_waddr  = addr_below;
                mem_wdata  = top_reg;
                state_next = S_EMIT;
            end

            S_DIV_WAIT: begin
                if (div_done) begin
                    mem_we     = 1'b1;
                    mem_waddr  = addr_below;
                    mem_wdata  = div_quo;
                    cnt_next   = cnt_m1;
                    state_next = S_EMIT;
                end
            end

            S_LIST_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = list_reg;
                state_next = S_LIST_WAIT;
            end

            S_LIST_WAIT: begin
                res_status_next = rpn_pkg::STAT_SHOWN;
                res_value_next  = rd_data_reg;
                res_last_next   = (list_reg == '0);
                state_next      = S_EMIT;
            end

            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_value_reg;
                    m_user_next  = res_status_reg;
                    m_last_next  = res_last_reg;
                    if ((op_reg == rpn_pkg::OP_SHOW_ALL) && !res_last_reg) begin
                        list_next  = list_reg - ADDR_W'(1);
                        state_next = S_LIST_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Stack memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        top_reg        <= top_next;
        below_reg      <= below_next;
        list_reg       <= list_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_last_reg   <= res_last_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/rpn_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module rpn_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rpn_pkg::DATA_W-1:0] dividend,
    input  logic [rpn_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [rpn_pkg::DATA_W-1:0] quotient
);

    localparam int DW     = rpn_pkg::DATA_W;
    localparam int STEP_W = $clog2(DW);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DW - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg,  neg_next;
    logic [DW-1:0]     rem_reg,  rem_next;
    logic [DW-1:0]     quo_reg,  quo_next;
    logic [DW-1:0]     dvs_reg,  dvs_next;

    logic [DW:0]       shifted;
    logic [DW:0]       trial;

    // Magnitudes: the most negative value maps onto itself as an unsigned number.
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[DW-1] ^ divisor[DW-1];
            rem_next  = '0;
            quo_next  = dividend[DW-1] ? (DW'(0) - dividend) : dividend;
            dvs_next  = divisor[DW-1] ? (DW'(0) - divisor) : divisor;
        end else if (busy_reg) begin
            if (!trial[DW]) begin
                rem_next = trial[DW-1:0];
            end else begin
                rem_next = shifted[DW-1:0];
            end
            quo_next  = {quo_reg[DW-2:0], ~trial[DW]};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DW'(0) - quo_reg) : quo_reg;

endmodule

/* rtl/rpn_sva.sv */
// Port-level checker of the stack calculator and its binding to the top level.
`timescale 1ns / 1ps
`include "rpn_stack_calculator_defines.svh"

module rpn_sva (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [rpn_pkg::DATA_W-1:0]   s_tdata,
    input logic [rpn_pkg::OP_W-1:0]     s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [rpn_pkg::DATA_W-1:0]   m_tdata,
    input logic [rpn_pkg::STATUS_W-1:0] m_tuser,
    input logic                         m_tlast
);

    property p_out_hold;
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast);
    endproperty

    property p_in_hold;
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser);
    endproperty

    property p_value_zero;
        m_tvalid && (m_tuser != rpn_pkg::STAT_SHOWN) |-> (m_tdata == '0);
    endproperty

    property p_status_last;
        m_tvalid && (m_tuser != rpn_pkg::STAT_SHOWN) |-> m_tlast;
    endproperty

    // A stalled result item keeps its place and its contents.
    `RPN_ASSERT_RST(a_out_hold, p_out_hold, "result item changed while stalled")

    // An input item offered but not yet taken stays on the bus unchanged.
    `RPN_ASSERT_RST(a_in_hold, p_in_hold, "input item changed while waiting")

    // Only a shown entry carries a value.
    `RPN_ASSERT_RST(a_value_zero, p_value_zero, "non-zero value on a result showing no entry")

    // Any status other than a shown entry ends the operation's results.
    `RPN_ASSERT_RST(a_status_last, p_status_last, "non-listing result without last marker")

    // Reset leaves no result pending and the input open.
    `RPN_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid && s_tready, "block not idle after reset")

endmodule

bind rpn_stack_calculator rpn_sva u_rpn_sva (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
